### hw/rtl/cag_pkg.sv
// ----------------------------------------------------------------------------
// cag_pkg
// Shared types and constants of the cave automaton generation step.
// ----------------------------------------------------------------------------
package cag_pkg;

  localparam int MAX_COLS_DEF = 64;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int LIMIT_W    = 4;
  localparam int COLS_W     = 7;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 7;
  localparam int COUNT_W    = 4;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BIRTH_LIMIT = 2'd0,
    REG_DEATH_LIMIT = 2'd1,
    REG_NUM_COLS    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] birth_limit;
    logic [LIMIT_W-1:0] death_limit;
    logic [COLS_W-1:0]  num_cols;
  } cag_cfg_t;

  localparam logic [LIMIT_W-1:0] BIRTH_LIMIT_RST = 4'd4;
  localparam logic [LIMIT_W-1:0] DEATH_LIMIT_RST = 4'd3;
  localparam logic [COLS_W-1:0]  NUM_COLS_RST    = 7'd64;

endpackage

### hw/rtl/cag_evolve.sv
// ----------------------------------------------------------------------------
// cag_evolve
// Next-generation rule for one row given the rows above and below it.
// ----------------------------------------------------------------------------
module cag_evolve #(
  parameter int ROW_W = cag_pkg::MAX_COLS_DEF
) (
  input  cag_pkg::cag_cfg_t  cfg,
  input  logic [ROW_W-1:0]   above,
  input  logic [ROW_W-1:0]   mid,
  input  logic [ROW_W-1:0]   below,
  output logic [ROW_W-1:0]   result
);
  import cag_pkg::*;

  logic [ROW_W-1:0] mask;
  logic [ROW_W+1:0] a_ext;
  logic [ROW_W+1:0] m_ext;
  logic [ROW_W+1:0] b_ext;
  logic [ROW_W-1:0] next_row;

  always_comb begin
    for (int j = 0; j < ROW_W; j++) begin
      mask[j] = (COLS_W'(j) < cfg.num_cols);
    end
  end

  // out-of-grid cells count as alive
  assign a_ext = {1'b1, (above & mask) | ~mask, 1'b1};
  assign m_ext = {1'b1, (mid & mask) | ~mask, 1'b1};
  assign b_ext = {1'b1, (below & mask) | ~mask, 1'b1};

  always_comb begin
    logic [COUNT_W-1:0] cnt;
    for (int j = 0; j < ROW_W; j++) begin
      cnt = COUNT_W'(a_ext[j]) + COUNT_W'(a_ext[j+1]) + COUNT_W'(a_ext[j+2])
          + COUNT_W'(m_ext[j]) + COUNT_W'(m_ext[j+2])
          + COUNT_W'(b_ext[j]) + COUNT_W'(b_ext[j+1]) + COUNT_W'(b_ext[j+2]);
      if (m_ext[j+1]) begin
        next_row[j] = (cnt >= cfg.death_limit);
      end else begin
        next_row[j] = (cnt > cfg.birth_limit);
      end
    end
  end

  assign result = next_row & mask;

endmodule

### hw/rtl/cag_out_fifo.sv
// ----------------------------------------------------------------------------
// cag_out_fifo
// Small result queue taking up to two rows per cycle, one out per cycle while pop_ready is high.
// ----------------------------------------------------------------------------
module cag_out_fifo #(
  parameter int ENTRY_W = cag_pkg::MAX_COLS_DEF + 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [1:0]                      push_n,
  input  logic [ENTRY_W-1:0]              push_a,
  input  logic [ENTRY_W-1:0]              push_b,
  output logic [cag_pkg::FIFO_CNT_W-1:0]  count,
  output logic                            pop_valid,
  input  logic                            pop_ready,
  output logic [ENTRY_W-1:0]              pop_data
);
  import cag_pkg::*;

  logic [ENTRY_W-1:0]    mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;
  logic                  pop;

  assign pop_valid = (count_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = mem_r[rd_ptr_r];
  assign count     = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(push_n);
    rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(pop);
    count_nxt  = count_r + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= push_a;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_r + FIFO_PTR_W'(1)] <= push_b;
    end
  end

endmodule

### hw/rtl/cave_automaton_generation_step.sv
// ----------------------------------------------------------------------------
// cave_automaton_generation_step
// One generation of a cave cellular automaton, fed one grid row at a time.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one grid row per transaction, tdata = row cells (bit j = column j),
//           tlast marks the final row of the grid.
//   out_* : next-generation rows in grid order, tlast on the final row.
//   cfg_* : write birth limit, death limit and column count while idle.
// The first row of a grid gives no result; each later row gives the new
// version of the row before it; the final row also gives its own new row.
// Each result passes the input register and the result queue to the output.
// Throughput: one row per cycle while in_tready is high; a final row that
// flushes two results sends them one at a time. Rate is set by the
// one-row-per-cycle evolve stage and single-entry-per-cycle queue read port.
// Reset clears the row window, the pipeline and the result queue and loads
// the default limits. When the receiver stalls, results collect in a
// four-entry queue and in_tready drops before it can overflow.
// ----------------------------------------------------------------------------
module cave_automaton_generation_step #(
  parameter int MAX_COLS = cag_pkg::MAX_COLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // row_cells, zero padded to whole bytes
  input  logic [((MAX_COLS+7)/8)*8-1:0]   in_tdata,
  input  logic                            in_tlast,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // new_row_cells, zero padded to whole bytes
  output logic [((MAX_COLS+7)/8)*8-1:0]   out_tdata,
  output logic                            out_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_we,
  input  logic [cag_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [cag_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import cag_pkg::*;

  localparam int DATA_W = ((MAX_COLS + 7) / 8) * 8;

  cag_cfg_t              cfg_r;
  logic [MAX_COLS-1:0]   row_above_r;
  logic [MAX_COLS-1:0]   row_middle_r;
  logic                  middle_valid_r;

  logic                  s1_valid_r;
  logic                  s1_has_mid_r;
  logic                  s1_last_r;
  logic [MAX_COLS-1:0]   s1_above_r;
  logic [MAX_COLS-1:0]   s1_mid_r;
  logic [MAX_COLS-1:0]   s1_row_r;

  logic                  in_accept;
  logic [MAX_COLS-1:0]   in_row;
  logic [1:0]            s1_n;
  logic [MAX_COLS-1:0]   res_mid;
  logic [MAX_COLS-1:0]   res_last;
  logic [MAX_COLS-1:0]   last_above;
  logic [1:0]            push_n;
  logic [MAX_COLS:0]     push_a;
  logic [MAX_COLS:0]     push_b;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [MAX_COLS:0]     pop_data;

  assign in_row    = in_tdata[MAX_COLS-1:0];
  assign in_accept = in_tvalid && in_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.birth_limit <= BIRTH_LIMIT_RST;
      cfg_r.death_limit <= DEATH_LIMIT_RST;
      cfg_r.num_cols    <= NUM_COLS_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_BIRTH_LIMIT: cfg_r.birth_limit <= cfg_wdata[LIMIT_W-1:0];
        REG_DEATH_LIMIT: cfg_r.death_limit <= cfg_wdata[LIMIT_W-1:0];
        REG_NUM_COLS:    cfg_r.num_cols    <= cfg_wdata[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  // row window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_above_r    <= '1;
      row_middle_r   <= '0;
      middle_valid_r <= 1'b0;
    end else if (in_accept) begin
      if (in_tlast) begin
        row_above_r    <= '1;
        row_middle_r   <= '0;
        middle_valid_r <= 1'b0;
      end else begin
        if (middle_valid_r) begin
          row_above_r <= row_middle_r;
        end
        row_middle_r   <= in_row;
        middle_valid_r <= 1'b1;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_has_mid_r <= middle_valid_r;
      s1_last_r    <= in_tlast;
      s1_above_r   <= row_above_r;
      s1_mid_r     <= row_middle_r;
      s1_row_r     <= in_row;
    end
  end

  assign s1_n = s1_valid_r ? (2'(s1_has_mid_r) + 2'(s1_last_r)) : 2'd0;

  // hold input while the queue could not absorb another two-row flush
  assign in_tready = (FIFO_CNT_W'(fifo_count + FIFO_CNT_W'(s1_n))
                      <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  assign last_above = s1_has_mid_r ? s1_mid_r : s1_above_r;

  cag_evolve #(
    .ROW_W (MAX_COLS)
  ) u_evolve_mid (
    .cfg    (cfg_r),
    .above  (s1_above_r),
    .mid    (s1_mid_r),
    .below  (s1_row_r),
    .result (res_mid)
  );

  cag_evolve #(
    .ROW_W (MAX_COLS)
  ) u_evolve_last (
    .cfg    (cfg_r),
    .above  (last_above),
    .mid    (s1_row_r),
    .below  ({MAX_COLS{1'b1}}),
    .result (res_last)
  );

  always_comb begin
    push_n = s1_n;
    push_b = {1'b1, res_last};
    if (s1_has_mid_r) begin
      push_a = {1'b0, res_mid};
    end else begin
      push_a = {1'b1, res_last};
    end
  end

  cag_out_fifo #(
    .ENTRY_W (MAX_COLS + 1)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push_a    (push_a),
    .push_b    (push_b),
    .count     (fifo_count),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (pop_data)
  );

  assign out_tdata = DATA_W'(pop_data[MAX_COLS-1:0]);
  assign out_tlast = pop_data[MAX_COLS];

endmodule
